>>> rtl/core/yuvrgb_pkg.sv
package yuvrgb_pkg;

	// Output packing codes, as held in the format register
	typedef enum logic [1:0] {
		FMT_RGB555 = 2'd0,
		FMT_RGB565 = 2'd1,
		FMT_BGR24  = 2'd2,
		FMT_BGR32  = 2'd3
	} fmt_t;

	// Conversion path codes
	typedef enum logic {
		OP_STUDIO = 1'b0,
		OP_FULL   = 1'b1
	} op_t;

	localparam fmt_t FMT_RESET = FMT_BGR32;

	// APB map: one 32-bit register, index taken from the word address
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic REG_OUTPUT_FORMAT = 1'b0;

	// Width of the working sums; covers both paths with margin
	localparam int unsigned SUM_W = 28;

	// Studio-range 16.16 coefficients
	localparam logic signed [SUM_W-1:0] COEF_Y  = 28'sd76283;
	localparam logic signed [SUM_W-1:0] COEF_BV = 28'sd104595;
	localparam logic signed [SUM_W-1:0] COEF_GV = 28'sd53280;
	localparam logic signed [SUM_W-1:0] COEF_GU = 28'sd25690;
	localparam logic signed [SUM_W-1:0] COEF_RV = 28'sd132186;

	// Full-range 8.8 coefficients
	localparam logic signed [SUM_W-1:0] FR_VR = 28'sd359;
	localparam logic signed [SUM_W-1:0] FR_UG = 28'sd88;
	localparam logic signed [SUM_W-1:0] FR_VG = 28'sd183;
	localparam logic signed [SUM_W-1:0] FR_UB = 28'sd454;

	localparam logic [8:0] LUMA_OFFSET   = 9'd16;
	localparam logic [8:0] CHROMA_OFFSET = 9'd128;

endpackage

>>> rtl/core/yuvrgb_regs.sv
module yuvrgb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [yuvrgb_pkg::PADDR_W-1:0] paddr,
	input  logic [yuvrgb_pkg::PDATA_W-1:0] pwdata,
	output logic [yuvrgb_pkg::PDATA_W-1:0] prdata,
	output logic                           pready,
	output yuvrgb_pkg::fmt_t               fmt
);
	import yuvrgb_pkg::*;

	fmt_t fmt_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_OUTPUT_FORMAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RESET;
		end else if (wr_en) begin
			fmt_q <= fmt_t'(pwdata[1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_OUTPUT_FORMAT) begin
			prdata = {{(PDATA_W-2){1'b0}}, fmt_q};
		end
	end

	assign fmt = fmt_q;

endmodule

>>> rtl/core/yuvrgb_pixel.sv
module yuvrgb_pixel (
	input  yuvrgb_pkg::op_t  op,
	input  yuvrgb_pkg::fmt_t fmt,
	input  logic [7:0]       luma,
	input  logic [7:0]       chroma_blue,
	input  logic [7:0]       chroma_red,
	output logic [23:0]      pixel
);
	import yuvrgb_pkg::*;

	logic signed [8:0]       y_off;
	logic signed [8:0]       u_off;
	logic signed [8:0]       v_off;
	logic signed [SUM_W-1:0] y_x;
	logic signed [SUM_W-1:0] yf_x;
	logic signed [SUM_W-1:0] u_x;
	logic signed [SUM_W-1:0] v_x;
	logic signed [SUM_W-1:0] ys;
	logic signed [SUM_W-1:0] sum_r;
	logic signed [SUM_W-1:0] sum_g;
	logic signed [SUM_W-1:0] sum_b;
	logic [7:0]              r;
	logic [7:0]              g;
	logic [7:0]              b;

	// Studio clip: above 0xFFFFFF saturates, at most 0xFFFF floors, else bits 23..16
	function automatic logic [7:0] clip_hi(input logic signed [SUM_W-1:0] x);
		logic [7:0] res;
		if (x[SUM_W-1]) begin
			res = 8'd0;
		end else if (|x[SUM_W-2:24]) begin
			res = 8'hFF;
		end else begin
			res = x[23:16];
		end
		return res;
	endfunction

	// Full-range clip: above 0xFFFF saturates, at most 0xFF floors, else bits 15..8
	function automatic logic [7:0] clip_lo(input logic signed [SUM_W-1:0] x);
		logic [7:0] res;
		if (x[SUM_W-1]) begin
			res = 8'd0;
		end else if (|x[SUM_W-2:16]) begin
			res = 8'hFF;
		end else begin
			res = x[15:8];
		end
		return res;
	endfunction

	always_comb begin
		y_off = $signed({1'b0, luma}) - $signed(LUMA_OFFSET);
		u_off = $signed({1'b0, chroma_blue}) - $signed(CHROMA_OFFSET);
		v_off = $signed({1'b0, chroma_red}) - $signed(CHROMA_OFFSET);
		y_x   = {{(SUM_W-9){y_off[8]}}, y_off};
		yf_x  = {{(SUM_W-16){1'b0}}, luma, 8'd0};
		u_x   = {{(SUM_W-9){u_off[8]}}, u_off};
		v_x   = {{(SUM_W-9){v_off[8]}}, v_off};

		if (op == OP_STUDIO) begin
			ys    = y_x * COEF_Y;
			sum_r = ys + v_x * COEF_BV;
			sum_g = ys - v_x * COEF_GV - u_x * COEF_GU;
			sum_b = ys + u_x * COEF_RV;
			r     = clip_hi(sum_r);
			g     = clip_hi(sum_g);
			b     = clip_hi(sum_b);
		end else begin
			ys    = yf_x;
			sum_r = ys + v_x * FR_VR;
			sum_g = ys - u_x * FR_UG - v_x * FR_VG;
			sum_b = ys + u_x * FR_UB;
			r     = clip_lo(sum_r);
			g     = clip_lo(sum_g);
			b     = clip_lo(sum_b);
		end

		case (fmt) inside
			FMT_RGB555: pixel = {9'd0, r[7:3], g[7:3], b[7:3]};
			FMT_RGB565: pixel = {8'd0, r[7:3], g[7:2], b[7:3]};
			FMT_BGR24, FMT_BGR32: pixel = {r, g, b};
			default: pixel = {r, g, b};
		endcase
	end

endmodule

>>> rtl/core/yuv_to_packed_rgb_converter_top.sv
// Pipeline: an input transfer passes through the input register and then the result register
// before out_valid rises. Throughput: one pixel pair per cycle unless the result side stalls;
// both pixels are converted in parallel between the two registers, and a stalled result holds
// while one more item waits.
// Reset (arst_n low, asynchronous): both stages empty, output format set to 32-bit BGR.
module yuv_to_packed_rgb_converter_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           op,
	input  logic [7:0]                     luma_first,
	input  logic [7:0]                     luma_second,
	input  logic [7:0]                     chroma_blue,
	input  logic [7:0]                     chroma_red,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [23:0]                    pixel_first,
	output logic [23:0]                    pixel_second,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [yuvrgb_pkg::PADDR_W-1:0] paddr,
	input  logic [yuvrgb_pkg::PDATA_W-1:0] pwdata,
	output logic [yuvrgb_pkg::PDATA_W-1:0] prdata,
	output logic                           pready
);
	import yuvrgb_pkg::*;

	fmt_t       fmt;
	logic       valid_s1;
	logic       valid_s2;
	logic       adv_s1;
	logic       adv_s2;
	op_t        op_s1;
	logic [7:0] luma_first_s1;
	logic [7:0] luma_second_s1;
	logic [7:0] chroma_blue_s1;
	logic [7:0] chroma_red_s1;
	logic [23:0] pix_first;
	logic [23:0] pix_second;
	logic [23:0] pixel_first_s2;
	logic [23:0] pixel_second_s2;

	yuvrgb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.fmt     (fmt)
	);

	// Advance the result stage when it is empty or being drained
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			op_s1          <= op_t'(op);
			luma_first_s1  <= luma_first;
			luma_second_s1 <= luma_second;
			chroma_blue_s1 <= chroma_blue;
			chroma_red_s1  <= chroma_red;
		end
		if (adv_s2 && valid_s1) begin
			pixel_first_s2  <= pix_first;
			pixel_second_s2 <= pix_second;
		end
	end

	yuvrgb_pixel u_pix_first (
		.op          (op_s1),
		.fmt         (fmt),
		.luma        (luma_first_s1),
		.chroma_blue (chroma_blue_s1),
		.chroma_red  (chroma_red_s1),
		.pixel       (pix_first)
	);

	yuvrgb_pixel u_pix_second (
		.op          (op_s1),
		.fmt         (fmt),
		.luma        (luma_second_s1),
		.chroma_blue (chroma_blue_s1),
		.chroma_red  (chroma_red_s1),
		.pixel       (pix_second)
	);

	assign out_valid    = valid_s2;
	assign pixel_first  = pixel_first_s2;
	assign pixel_second = pixel_second_s2;

endmodule

>>> rtl/core/yuvrgb_checker.sv
module yuvrgb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [23:0]                    pixel_first,
	input logic [23:0]                    pixel_second,
	input logic                           psel,
	input logic                           penable,
	input logic                           pwrite,
	input logic [yuvrgb_pkg::PADDR_W-1:0] paddr,
	input logic [yuvrgb_pkg::PDATA_W-1:0] pwdata
);
	import yuvrgb_pkg::*;

	fmt_t fmt_q;

	// Mirror the format register from observed APB writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_OUTPUT_FORMAT)) begin
			fmt_q <= fmt_t'(pwdata[1:0]);
		end
	end

	// Input side stalls only behind a full, stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while result side could move");

	// An item accepted while no result is shown reaches the output through both registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !out_valid) |=> ##1 out_valid)
		else $error("accepted item did not reach the output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pixel_first)
			&& $stable(pixel_second)))
		else $error("stalled result changed");

	// Narrow formats leave the unused top bits clear
	a_narrow_pack: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (fmt_q == FMT_RGB555 || fmt_q == FMT_RGB565)) |->
			(pixel_first[23:16] == 8'd0 && pixel_second[23:16] == 8'd0
			&& (fmt_q != FMT_RGB555 || (!pixel_first[15] && !pixel_second[15]))))
		else $error("upper bits set in 16-bit packing");

endmodule

bind yuv_to_packed_rgb_converter_top yuvrgb_checker u_yuvrgb_checker (.*);

>>> tb/sv/yuvrgb_pair_checker.sv
module yuvrgb_pair_checker
	import yuvrgb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               op,
	input  logic [7:0]         luma_first,
	input  logic [7:0]         luma_second,
	input  logic [7:0]         chroma_blue,
	input  logic [7:0]         chroma_red,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [23:0]        pixel_first,
	input  logic [23:0]        pixel_second,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic [PDATA_W-1:0] prdata,
	input  logic               pready,
	output int unsigned        fail_count,
	output int unsigned        pending,
	output int unsigned        pairs_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// Studio-range gains, 16.16
	localparam longint STUDIO_Y  = 76283;
	localparam longint STUDIO_VR = 104595;
	localparam longint STUDIO_VG = 53280;
	localparam longint STUDIO_UG = 25690;
	localparam longint STUDIO_UB = 132186;
	// Full-range gains, 8.8
	localparam longint FULL_VR = 359;
	localparam longint FULL_UG = 88;
	localparam longint FULL_VG = 183;
	localparam longint FULL_UB = 454;

	typedef struct packed {
		logic [23:0] first;
		logic [23:0] second;
	} pixel_pair_t;

	pixel_pair_t pairs_due[$];
	fmt_t        fmt_now;

	function automatic logic [7:0] clip_studio(input longint s);
		if (s > 16777215)
			return 8'hff;
		else if (s <= 65535)
			return 8'h00;
		else
			return s[23:16];
	endfunction

	function automatic logic [7:0] clip_full(input longint s);
		if (s > 65535)
			return 8'hff;
		else if (s <= 255)
			return 8'h00;
		else
			return s[15:8];
	endfunction

	function automatic logic [23:0] pack_rgb(input fmt_t f, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		case (f)
			FMT_RGB555: return {9'd0, r[7:3], g[7:3], b[7:3]};
			FMT_RGB565: return {8'd0, r[7:3], g[7:2], b[7:3]};
			default:    return {r, g, b};
		endcase
	endfunction

	function automatic logic [23:0] predict_pixel(input op_t path, input logic [7:0] y,
			input logic [7:0] cb, input logic [7:0] cr, input fmt_t f);
		longint u, v, ys;
		logic [7:0] r, g, b;
		u = longint'(cb) - 128;
		v = longint'(cr) - 128;
		if (path == OP_STUDIO) begin
			ys = (longint'(y) - 16) * STUDIO_Y;
			r = clip_studio(ys + STUDIO_VR * v);
			g = clip_studio(ys - STUDIO_VG * v - STUDIO_UG * u);
			b = clip_studio(ys + STUDIO_UB * u);
		end else begin
			ys = longint'(y) * 256;
			r = clip_full(ys + FULL_VR * v);
			g = clip_full(ys - FULL_UG * u - FULL_VG * v);
			b = clip_full(ys + FULL_UB * u);
		end
		return pack_rgb(f, r, g, b);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_pair_t want;
		int unsigned fails;
		logic        hit_format;
		if (!arst_n) begin
			fmt_now = FMT_RESET;
			pairs_due.delete();
			fail_count <= 0;
			pending <= 0;
			pairs_checked <= 0;
		end else begin
			fails = 0;
			hit_format = (paddr[PADDR_W-1:2] == REG_OUTPUT_FORMAT);
			if (out_valid && out_ready) begin
				if (pairs_due.size() == 0) begin
					$display("%0t: pixel pair %06h %06h with none expected", $time,
						pixel_first, pixel_second);
					fails++;
				end else begin
					want = pairs_due.pop_front();
					if (pixel_first !== want.first) begin
						$display("%0t: pixel_first expected %06h got %06h", $time,
							want.first, pixel_first);
						fails++;
					end
					if (pixel_second !== want.second) begin
						$display("%0t: pixel_second expected %06h got %06h", $time,
							want.second, pixel_second);
						fails++;
					end
					pairs_checked <= pairs_checked + 1;
				end
			end
			if (in_valid && in_ready)
				pairs_due.push_back('{
					first:  predict_pixel(op_t'(op), luma_first, chroma_blue, chroma_red,
						fmt_now),
					second: predict_pixel(op_t'(op), luma_second, chroma_blue, chroma_red,
						fmt_now)
				});
			if (psel && penable && pready && hit_format) begin
				if (pwrite) begin
					fmt_now = fmt_t'(pwdata[1:0]);
				end else if (prdata[1:0] !== fmt_now) begin
					$display("%0t: output_format read expected %0d got %0d", $time,
						fmt_now, prdata[1:0]);
					fails++;
				end
			end
			fail_count <= fail_count + fails;
			pending <= pairs_due.size();
		end
	end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import yuvrgb_pkg::*;

	localparam int unsigned LIMIT = 1_000_000;
	localparam int unsigned PAIRS_PER_PHASE = 300;
	localparam logic [PADDR_W-1:0] ADDR_FORMAT = PADDR_W'(REG_OUTPUT_FORMAT) << 2;
	// Word address with no register behind it
	localparam logic [PADDR_W-1:0] ADDR_SPARE = PADDR_W'(4);

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               op = 1'b0;
	logic [7:0]         luma_first = '0;
	logic [7:0]         luma_second = '0;
	logic [7:0]         chroma_blue = '0;
	logic [7:0]         chroma_red = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [23:0]        pixel_first;
	logic [23:0]        pixel_second;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int unsigned fail_count, pending, pairs_checked;
	int unsigned pairs_sent = 0;
	int unsigned cycles = 0;
	int unsigned ready_hold = 0;
	bit          steady = 1'b0;

	yuv_to_packed_rgb_converter_top u_dut (.*);

	yuvrgb_pair_checker u_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side backpressure: mostly ready, short stalls, now and then a long one
	always @(posedge clk) begin
		int unsigned pick;
		if (steady) begin
			out_ready <= 1'b1;
		end else if (ready_hold != 0) begin
			ready_hold--;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				out_ready <= 1'b1;
				ready_hold = $urandom_range(0, 8);
			end else if (pick < 95) begin
				out_ready <= 1'b0;
				ready_hold = $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b0;
				ready_hold = $urandom_range(10, 40);
			end
		end
	end

	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write the format with junk in the upper bits, poke the unused slot, read back
	task automatic set_format(input fmt_t f);
		apb_access(1'b1, ADDR_FORMAT, ($urandom() & ~32'd3) | 32'(f));
		apb_access(1'b1, ADDR_SPARE, $urandom());
		apb_access(1'b0, ADDR_FORMAT, '0);
	endtask

	// Drop valid and hold until every pair sent has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic int unsigned gap_len();
		int unsigned pick;
		if (steady)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		else if (pick < 90)
			return $urandom_range(1, 3);
		else if (pick < 98)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// Bias toward the ends and the chroma midpoint so the clip edges get hit
	function automatic logic [7:0] pick_sample();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return 8'($urandom_range(0, 255));
		else if (pick < 8)
			return $urandom_range(0, 1) ? 8'($urandom_range(248, 255))
				: 8'($urandom_range(0, 7));
		else
			return 8'($urandom_range(120, 136));
	endfunction

	task automatic send_pair(input op_t o, input logic [7:0] y0, input logic [7:0] y1,
			input logic [7:0] cb, input logic [7:0] cr);
		int unsigned gap;
		gap = gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		luma_first <= y0;
		luma_second <= y1;
		chroma_blue <= cb;
		chroma_red <= cr;
		do @(posedge clk); while (!in_ready);
		pairs_sent++;
	endtask

	initial begin
		fmt_t fmt_plan [6];
		op_t  path;
		fmt_plan = '{FMT_RGB555, FMT_RGB565, FMT_BGR24, FMT_BGR32, FMT_RGB565, FMT_RGB555};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset value of the format register
		apb_access(1'b0, ADDR_FORMAT, '0);

		for (int p = 0; p < 2; p++) begin
			path = op_t'(p);
			send_pair(path, 8'd0, 8'd255, 8'd128, 8'd128);
			send_pair(path, 8'd16, 8'd235, 8'd128, 8'd128);
			send_pair(path, 8'd255, 8'd0, 8'd255, 8'd255);
			send_pair(path, 8'd0, 8'd255, 8'd0, 8'd0);
			send_pair(path, 8'd128, 8'd128, 8'd0, 8'd255);
			send_pair(path, 8'd128, 8'd128, 8'd255, 8'd0);
			send_pair(path, 8'd255, 8'd15, 8'd255, 8'd0);
		end

		foreach (fmt_plan[k]) begin
			wait_drained();
			set_format(fmt_plan[k]);
			for (int i = 0; i < PAIRS_PER_PHASE; i++) begin
				// open each phase with back-to-back transfers on both sides
				steady = (i < 60);
				send_pair(op_t'($urandom_range(0, 1)), pick_sample(), pick_sample(),
					pick_sample(), pick_sample());
			end
		end

		wait_drained();
		steady = 1'b1;
		repeat (8) @(posedge clk);

		$display("Sent %0d pixel pairs, %0d checked, on both conversion paths", pairs_sent,
			pairs_checked);
		$display("Covered all four output packings plus writes to an unused address");
		if (pending != 0)
			$display("%0d pixel pairs never came out", pending);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
